[hdl/yrsp_pkg.sv]
// Shared types, field widths and fixed-point helpers for the yaw rotate/scale point block.
// No dependencies; used by the trig ROM, the rotate datapath and the top level.
package yrsp_pkg;

   // Field widths of the item ports
   localparam int POINT_WIDTH   = 32;
   localparam int HEADING_WIDTH = 16;

   // Q62 constants for building the trig table at elaboration
   localparam logic [63:0] Q62_ONE      = 64'h4000_0000_0000_0000;
   localparam logic [63:0] HALF_PI_Q62  = 64'h6487_ED51_10B4_611A;
   localparam int          SERIES_TERMS = 40;

   // Control that travels with an item from the input stage into the datapath
   typedef struct packed {
      logic       valid;
      logic [1:0] quad;
   } ctl_type;

   // (a * b) >> 62 over the full 128-bit product
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

endpackage

[hdl/yaw_rotate_scale_point_core.sv]
// Top level of the yaw rotate/scale point block: input stage, trig ROM and rotate datapath.
// Depends on yrsp_pkg, yrsp_trig_rom and yrsp_rotate.
//
// Takes one point per clock: an item is accepted whenever start is high, and busy is
// held low since nothing inside ever stalls. Each item produces exactly one result,
// shown on the rsp_ ports for one cycle with rsp_valid high; results come out in
// acceptance order and must be taken as they appear. An item passes through the input
// register with the registered trig ROM read, the product register, and the rounded
// result register. The heading is reduced modulo ANGLE_STEPS, which must be a power
// of two; the ROM holds one quarter turn (ANGLE_STEPS/4 entries of sine and cosine)
// and the other quadrants are folded from it. No clearing pass is needed after reset.
module yaw_rotate_scale_point_core #(
   parameter int ANGLE_STEPS        = 8192,
   parameter int TRIG_FRACTION_BITS = 15
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   output logic                                         busy,
   input  logic signed [yrsp_pkg::POINT_WIDTH-1:0]      req_point_x,
   input  logic signed [yrsp_pkg::POINT_WIDTH-1:0]      req_point_y,
   input  logic signed [yrsp_pkg::POINT_WIDTH-1:0]      req_point_z,
   input  logic        [yrsp_pkg::HEADING_WIDTH-1:0]    req_heading,
   output logic                                         rsp_valid,
   output logic signed [yrsp_pkg::POINT_WIDTH-1:0]      rsp_world_x,
   output logic signed [yrsp_pkg::POINT_WIDTH-1:0]      rsp_world_y,
   output logic signed [yrsp_pkg::POINT_WIDTH-1:0]      rsp_world_z
);

   localparam int PNT = yrsp_pkg::POINT_WIDTH;
   localparam int AB  = $clog2(ANGLE_STEPS);
   localparam int QW  = TRIG_FRACTION_BITS + 1;

   localparam logic [AB-1:0] HALF_TURN = AB'(ANGLE_STEPS / 2);

   logic                  accept;
   logic [AB-1:0]         angle_idx;
   yrsp_pkg::ctl_type     ctl_in, ctl_ff;
   logic signed [PNT-1:0] x_ff, y_ff, z_ff;
   logic [QW-1:0]         rom_sin, rom_cos;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Angle index = (half turn - heading) mod turn; top two bits pick the quadrant
   assign angle_idx    = HALF_TURN - req_heading[AB-1:0];
   assign ctl_in.valid = accept;
   assign ctl_in.quad  = angle_idx[AB-1:AB-2];

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (accept) begin
         ctl_ff.quad <= ctl_in.quad;
         x_ff        <= req_point_x;
         y_ff        <= req_point_y;
         z_ff        <= req_point_z;
      end
   end

   yrsp_trig_rom #(
      .ANGLE_STEPS        (ANGLE_STEPS),
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
   ) u_trig_rom (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (angle_idx[AB-3:0]),
      .rd_sin  (rom_sin),
      .rd_cos  (rom_cos)
   );

   yrsp_rotate #(
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
   ) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (ctl_ff),
      .in_x      (x_ff),
      .in_y      (y_ff),
      .in_z      (z_ff),
      .in_sin    (rom_sin),
      .in_cos    (rom_cos),
      .out_valid (rsp_valid),
      .out_x     (rsp_world_x),
      .out_y     (rsp_world_y),
      .out_z     (rsp_world_z)
   );

`ifndef SYNTHESIS
   // Every accepted item yields a result
   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("accepted item produced no result");

   // No result without a matching accepted item
   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("result without a matching item");

   // The y lane carries round(-y/4) of its accepted item
   a_y_lane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_world_y ==
         32'((34'sd2 - 34'($past(req_point_y, 3))) >>> 2)))
      else $error("world_y does not match its item");
`endif

endmodule

[hdl/yrsp_trig_rom.sv]
// Quarter-wave sine/cosine ROM, Q1.F magnitudes, with a registered read port.
// Depends on yrsp_pkg (mul_q62 and the Q62 constants); contents are built at elaboration.
module yrsp_trig_rom #(
   parameter int ANGLE_STEPS        = 8192,
   parameter int TRIG_FRACTION_BITS = 15
) (
   input  logic                              clock,
   input  logic                              rd_en,
   input  logic [$clog2(ANGLE_STEPS)-3:0]    rd_addr,
   output logic [TRIG_FRACTION_BITS:0]       rd_sin,
   output logic [TRIG_FRACTION_BITS:0]       rd_cos
);

   localparam int          QW         = TRIG_FRACTION_BITS + 1;
   localparam int          AB         = $clog2(ANGLE_STEPS);
   localparam int          QUARTER    = ANGLE_STEPS / 4;
   localparam logic [63:0] STEPS64    = 64'(ANGLE_STEPS);
   localparam logic [63:0] THETA_STEP = yrsp_pkg::HALF_PI_Q62 / STEPS64;
   localparam logic [63:0] THETA_REM  = yrsp_pkg::HALF_PI_Q62 % STEPS64;

   typedef logic [2*QW-1:0] rom_type [QUARTER];

   // Round a nonnegative Q62 value to F fraction bits
   function automatic logic [QW-1:0] round_q62(input logic [63:0] v);
      logic [63:0] rnd;
      rnd = (v + (64'd1 << (61 - TRIG_FRACTION_BITS))) >> (62 - TRIG_FRACTION_BITS);
      return rnd[QW-1:0];
   endfunction

   // Unsigned quotient by shift and subtract, used only while building the table
   function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = 65'd0;
      quo = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Taylor series for sin and cos of each first-quadrant step; entry = {sin, cos}
   function automatic rom_type build_table();
      rom_type     tab;
      logic [63:0] r;
      logic [63:0] theta;
      logic [63:0] t2;
      logic [63:0] term;
      logic [63:0] s_sum;
      logic [63:0] c_sum;
      logic [63:0] divisor;
      logic        neg;
      for (int e = 0; e < QUARTER; e++) begin
         r     = 64'(4 * e);
         theta = THETA_STEP * r + ((THETA_REM * r) >> AB);
         t2    = yrsp_pkg::mul_q62(theta, theta);
         // sine
         s_sum = 64'd0;
         term  = theta;
         neg   = 1'b0;
         for (int i = 0; i < yrsp_pkg::SERIES_TERMS; i++) begin
            if (term != 64'd0) begin
               s_sum   = neg ? s_sum - term : s_sum + term;
               divisor = 64'((2 * i + 2) * (2 * i + 3));
               term    = div_u64(yrsp_pkg::mul_q62(term, t2), divisor);
               neg     = !neg;
            end
         end
         // cosine
         c_sum = 64'd0;
         term  = yrsp_pkg::Q62_ONE;
         neg   = 1'b0;
         for (int i = 0; i < yrsp_pkg::SERIES_TERMS; i++) begin
            if (term != 64'd0) begin
               c_sum   = neg ? c_sum - term : c_sum + term;
               divisor = 64'((2 * i + 1) * (2 * i + 2));
               term    = div_u64(yrsp_pkg::mul_q62(term, t2), divisor);
               neg     = !neg;
            end
         end
         tab[e] = {round_q62(s_sum), round_q62(c_sum)};
      end
      return tab;
   endfunction

   localparam rom_type TRIG_TABLE = build_table();

   logic [2*QW-1:0] rd_data_ff;

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= TRIG_TABLE[rd_addr];
      end
   end

   assign rd_sin = rd_data_ff[2*QW-1:QW];
   assign rd_cos = rd_data_ff[QW-1:0];

endmodule

[hdl/yrsp_rotate.sv]
// Rotate/scale datapath: quadrant fold, four products, then sum and round to Q24.8.
// Depends on yrsp_pkg (ctl_type, field widths). Two register stages.
module yrsp_rotate #(
   parameter int TRIG_FRACTION_BITS = 15
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  yrsp_pkg::ctl_type                       in_ctl,
   input  logic signed [yrsp_pkg::POINT_WIDTH-1:0] in_x,
   input  logic signed [yrsp_pkg::POINT_WIDTH-1:0] in_y,
   input  logic signed [yrsp_pkg::POINT_WIDTH-1:0] in_z,
   input  logic        [TRIG_FRACTION_BITS:0]      in_sin,
   input  logic        [TRIG_FRACTION_BITS:0]      in_cos,
   output logic                                    out_valid,
   output logic signed [yrsp_pkg::POINT_WIDTH-1:0] out_x,
   output logic signed [yrsp_pkg::POINT_WIDTH-1:0] out_y,
   output logic signed [yrsp_pkg::POINT_WIDTH-1:0] out_z
);

   localparam int PNT = yrsp_pkg::POINT_WIDTH;
   localparam int TW  = TRIG_FRACTION_BITS + 2;   // signed trig, holds +/-1.0 exactly
   localparam int PW  = PNT + TW;                 // product width
   localparam int SW  = PW + 1;                   // sum width
   localparam int SH  = TRIG_FRACTION_BITS + 2;   // quarter scale plus trig fraction
   localparam int YW  = PNT + 2;                  // negated y with headroom

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (SH - 1);
   localparam logic signed [YW-1:0] Y_HALF     = YW'(2);

   logic signed [TW-1:0] s_pos;
   logic signed [TW-1:0] c_pos;
   logic signed [TW-1:0] sn;
   logic signed [TW-1:0] cs;

   logic signed [PW-1:0] prod_cx_in, prod_sz_in, prod_sx_in, prod_cz_in;
   logic signed [PW-1:0] prod_cx_ff, prod_sz_ff, prod_sx_ff, prod_cz_ff;
   logic signed [YW-1:0] y_sum;
   logic signed [PNT-1:0] ny_in, ny_ff;
   logic                 valid_ff;

   logic signed [SW-1:0] sum_x, sum_z;
   logic signed [PNT-1:0] out_x_in, out_z_in;
   logic signed [PNT-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic                 out_valid_ff;

   // Fold the first-quadrant magnitudes into the full turn
   always_comb begin
      s_pos = $signed({1'b0, in_sin});
      c_pos = $signed({1'b0, in_cos});
      case (in_ctl.quad)
         QUAD_FIRST: begin
            sn = s_pos;
            cs = c_pos;
         end
         QUAD_SECOND: begin
            sn = c_pos;
            cs = -s_pos;
         end
         QUAD_THIRD: begin
            sn = -s_pos;
            cs = -c_pos;
         end
         QUAD_FOURTH: begin
            sn = -c_pos;
            cs = s_pos;
         end
         default: begin
            sn = s_pos;
            cs = c_pos;
         end
      endcase
   end

   // Products, and y negated and quartered with ties toward plus infinity
   assign prod_cx_in = PW'(cs) * PW'(in_x);
   assign prod_sz_in = PW'(sn) * PW'(in_z);
   assign prod_sx_in = PW'(sn) * PW'(in_x);
   assign prod_cz_in = PW'(cs) * PW'(in_z);
   assign y_sum      = Y_HALF - YW'(in_y);
   assign ny_in      = y_sum[2 +: PNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_cx_ff <= prod_cx_in;
      prod_sz_ff <= prod_sz_in;
      prod_sx_ff <= prod_sx_in;
      prod_cz_ff <= prod_cz_in;
      ny_ff      <= ny_in;
   end

   // Sum, round to nearest and drop the trig fraction and quarter scale
   assign sum_x    = SW'(prod_cx_ff) - SW'(prod_sz_ff) + ROUND_HALF;
   assign sum_z    = SW'(prod_sx_ff) + SW'(prod_cz_ff) + ROUND_HALF;
   assign out_x_in = sum_x[SH +: PNT];
   assign out_z_in = sum_z[SH +: PNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff <= out_x_in;
      out_y_ff <= ny_ff;
      out_z_ff <= out_z_in;
   end

   assign out_valid = out_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_z     = out_z_ff;

endmodule

[verif/tb_yaw_rotate_scale_point_core.sv]
// Self-checking testbench for yaw_rotate_scale_point_core: directed and random points,
// each checked against a bit-exact rotate/scale predictor. Depends on yrsp_pkg and the core.
module tb_yaw_rotate_scale_point_core;

   localparam int          TURN_STEPS   = 8192;
   localparam int          TRIG_FRAC    = 15;
   localparam logic [63:0] QUARTER_PI2  = 64'h6487_ED51_10B4_611A; // pi/2 in Q62
   localparam logic [63:0] ONE_Q62      = 64'h4000_0000_0000_0000;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          DRAIN_LIMIT  = 200;
   localparam int          CORE_LATENCY = 3;

   typedef logic signed [yrsp_pkg::POINT_WIDTH-1:0] coord_type;
   typedef logic [yrsp_pkg::HEADING_WIDTH-1:0]      heading_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } world_point_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        start       = 1'b0;
   logic        busy;
   coord_type   req_point_x = '0;
   coord_type   req_point_y = '0;
   coord_type   req_point_z = '0;
   heading_type req_heading = '0;
   logic        rsp_valid;
   coord_type   rsp_world_x;
   coord_type   rsp_world_y;
   coord_type   rsp_world_z;

   world_point_type pending_points[$];
   world_point_type oldest_point;
   int              mismatch_count = 0;
   int              cycle_count    = 0;

   yaw_rotate_scale_point_core DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .req_heading (req_heading),
      .rsp_valid   (rsp_valid),
      .rsp_world_x (rsp_world_x),
      .rsp_world_y (rsp_world_y),
      .rsp_world_z (rsp_world_z)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // Q62 fixed-point product, upper part of the 128-bit result
   function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      return wide[125:62];
   endfunction

   // Q62 series value rounded to TRIG_FRAC fraction bits
   function automatic logic signed [63:0] trig_round(input logic [63:0] v);
      logic [63:0] sum;
      sum = v + (64'd1 << (61 - TRIG_FRAC));
      return $signed(sum >> (62 - TRIG_FRAC));
   endfunction

   // Signed divide by 2^sh, rounded to nearest, ties toward plus infinity
   function automatic logic signed [63:0] round_div_pow2(input logic signed [63:0] v,
                                                         input int sh);
      logic signed [63:0] biased;
      biased = v + (64'sd1 <<< (sh - 1));
      return biased >>> sh;
   endfunction

   // Sine and cosine for angle index k, folded from the first quadrant
   task automatic yaw_sin_cos(input int k, output logic signed [63:0] sn,
                              output logic signed [63:0] cs);
      logic [63:0]        steps;
      logic [63:0]        k4;
      logic [63:0]        quad;
      logic [63:0]        r;
      logic [63:0]        theta;
      logic [63:0]        t2;
      logic [63:0]        term;
      logic [63:0]        s_sum;
      logic [63:0]        c_sum;
      logic [63:0]        divisor;
      logic               neg;
      logic signed [63:0] s;
      logic signed [63:0] c;
      steps = TURN_STEPS;
      k4    = 64'(k) * 64'd4;
      quad  = k4 / steps;
      r     = k4 - quad * steps;
      theta = (QUARTER_PI2 / steps) * r + ((QUARTER_PI2 % steps) * r) / steps;
      t2    = q62_product(theta, theta);
      // sine series
      s_sum = '0;
      term  = theta;
      neg   = 1'b0;
      for (int i = 0; i < 40 && term != 0; i++) begin
         s_sum   = neg ? s_sum - term : s_sum + term;
         divisor = 64'((2 * i + 2) * (2 * i + 3));
         term    = q62_product(term, t2) / divisor;
         neg     = ~neg;
      end
      // cosine series
      c_sum = '0;
      term  = ONE_Q62;
      neg   = 1'b0;
      for (int i = 0; i < 40 && term != 0; i++) begin
         c_sum   = neg ? c_sum - term : c_sum + term;
         divisor = 64'((2 * i + 1) * (2 * i + 2));
         term    = q62_product(term, t2) / divisor;
         neg     = ~neg;
      end
      s = trig_round(s_sum);
      c = trig_round(c_sum);
      case (quad[1:0])
         2'd0: begin
            sn = s;  cs = c;
         end
         2'd1: begin
            sn = c;  cs = -s;
         end
         2'd2: begin
            sn = -s; cs = -c;
         end
         default: begin
            sn = -c; cs = s;
         end
      endcase
   endtask

   // Quarter-scaled yaw rotation of one point, y negated
   task automatic rotate_point(input coord_type px, input coord_type py, input coord_type pz,
                               input heading_type hd, output world_point_type wp);
      int                 k;
      logic signed [63:0] sn;
      logic signed [63:0] cs;
      logic signed [63:0] x64;
      logic signed [63:0] y64;
      logic signed [63:0] z64;
      logic signed [63:0] rx;
      logic signed [63:0] ry;
      logic signed [63:0] rz;
      k = (TURN_STEPS / 2 + TURN_STEPS - (int'(hd) % TURN_STEPS)) % TURN_STEPS;
      yaw_sin_cos(k, sn, cs);
      x64  = px;
      y64  = py;
      z64  = pz;
      rx   = round_div_pow2(cs * x64 - sn * z64, TRIG_FRAC + 2);
      ry   = round_div_pow2(-y64, 2);
      rz   = round_div_pow2(sn * x64 + cs * z64, TRIG_FRAC + 2);
      wp.x = rx[yrsp_pkg::POINT_WIDTH-1:0];
      wp.y = ry[yrsp_pkg::POINT_WIDTH-1:0];
      wp.z = rz[yrsp_pkg::POINT_WIDTH-1:0];
   endtask

   // ---------------------------------------------------------------- driver

   // Present one item and hold it until the core takes it
   task automatic send_point(input coord_type px, input coord_type py, input coord_type pz,
                             input heading_type hd);
      world_point_type wp;
      req_point_x <= px;
      req_point_y <= py;
      req_point_z <= pz;
      req_heading <= hd;
      start       <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      rotate_point(px, py, pz, hd, wp);
      pending_points.push_back(wp);
   endtask

   // Drop start and put junk on the payload ports while idling
   task automatic idle_cycles(input int n);
      start       <= 1'b0;
      req_point_x <= $urandom;
      req_point_y <= $urandom;
      req_point_z <= $urandom;
      req_heading <= $urandom;
      repeat (n) @(posedge clock);
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(yrsp_pkg::POINT_WIDTH-1){1'b0}}};
         1: return {1'b0, {(yrsp_pkg::POINT_WIDTH-1){1'b1}}};
         2: return coord_type'($urandom_range(0, 4095)) - 2048;
         default: return $urandom;
      endcase
   endfunction

   function automatic heading_type rand_heading();
      case ($urandom_range(0, 5))
         0: return heading_type'($urandom_range(0, 3) * (TURN_STEPS / 4)
                                 + $urandom_range(0, 7) * TURN_STEPS);
         1: return heading_type'($urandom_range(TURN_STEPS, 65535));
         default: return heading_type'($urandom_range(0, 65535));
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // Headings whose sine or cosine is an exact 1.0, plus wrap past a turn
   task automatic test_cardinal_headings();
      coord_type cmin;
      coord_type cmax;
      cmin = {1'b1, {(yrsp_pkg::POINT_WIDTH-1){1'b0}}};
      cmax = {1'b0, {(yrsp_pkg::POINT_WIDTH-1){1'b1}}};
      send_point('0, '0, '0, 16'd0);
      send_point(cmax, cmax, cmax, 16'd4096);
      send_point(cmin, cmin, cmin, 16'd4096);
      send_point(cmax, 32'sd1000, cmin, 16'd0);
      send_point(cmin, -32'sd1000, cmax, 16'd2048);
      send_point(cmax, cmin, cmax, 16'd6144);
      send_point(cmin, cmax, cmin, 16'hFFFF);
      send_point(32'sd256, 32'sd512, -32'sd768, 16'hF000);
      idle_cycles(3);
   endtask

   // Diagonal headings and neighbors of quadrant edges at full-scale coordinates
   task automatic test_extreme_coords();
      coord_type cmin;
      coord_type cmax;
      cmin = {1'b1, {(yrsp_pkg::POINT_WIDTH-1){1'b0}}};
      cmax = {1'b0, {(yrsp_pkg::POINT_WIDTH-1){1'b1}}};
      send_point(cmax, cmax, cmax, 16'd1024);
      send_point(cmin, cmin, cmax, 16'd3072);
      send_point(cmin, cmax, cmin, 16'd5120);
      send_point(cmax, cmin, cmin, 16'd7168);
      send_point(cmax, 32'sd1, cmax, 16'd1);
      send_point(cmin, -32'sd1, cmin, 16'd8191);
      send_point(cmax, cmax, cmin, 16'd4095);
      send_point(cmin, cmin, cmax, 16'd4097);
      idle_cycles(2);
   endtask

   // Half-way cases of the final rounding go toward plus infinity
   task automatic test_rounding_ties();
      send_point(32'sd2, 32'sd2, 32'sd0, 16'd4096);
      send_point(-32'sd2, -32'sd2, 32'sd0, 16'd4096);
      send_point(32'sd0, 32'sd6, 32'sd2, 16'd4096);
      send_point(32'sd0, -32'sd6, -32'sd2, 16'd4096);
      send_point(32'sd6, 32'sd3, -32'sd2, 16'd2048);
      idle_cycles(4);
   endtask

   // Random points with random idle bursts between items
   task automatic test_random_points(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 13));
         send_point(rand_coord(), rand_coord(), rand_coord(), rand_heading());
      end
   endtask

   // Back-to-back items at full rate
   task automatic test_streaming(input int count);
      for (int i = 0; i < count; i++) begin
         send_point(rand_coord(), rand_coord(), rand_coord(), rand_heading());
      end
      start <= 1'b0;
   endtask

   // ---------------------------------------------------------------- checker

   // Compare each result with the oldest pending point
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            $display("%0t unexpected result: expected none, got x=%0d y=%0d z=%0d",
                     $time, rsp_world_x, rsp_world_y, rsp_world_z);
            mismatch_count++;
         end else begin
            oldest_point = pending_points.pop_front();
            if (rsp_world_x !== oldest_point.x) begin
               $display("%0t world_x mismatch: expected %0d, got %0d",
                        $time, oldest_point.x, rsp_world_x);
               mismatch_count++;
            end
            if (rsp_world_y !== oldest_point.y) begin
               $display("%0t world_y mismatch: expected %0d, got %0d",
                        $time, oldest_point.y, rsp_world_y);
               mismatch_count++;
            end
            if (rsp_world_z !== oldest_point.z) begin
               $display("%0t world_z mismatch: expected %0d, got %0d",
                        $time, oldest_point.z, rsp_world_z);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int drain;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_cardinal_headings();
      test_extreme_coords();
      test_rounding_ties();
      test_random_points(900);
      test_streaming(150);

      // let the pipeline empty out
      drain = 0;
      while (pending_points.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      if (pending_points.size() != 0) begin
         $display("%0t results missing: expected %0d more, got none",
                  $time, pending_points.size());
         mismatch_count++;
      end
      repeat (CORE_LATENCY + 5) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
hdl/yrsp_pkg.sv
hdl/yrsp_trig_rom.sv
hdl/yrsp_rotate.sv
hdl/yaw_rotate_scale_point_core.sv
verif/tb_yaw_rotate_scale_point_core.sv
